// ===== hw/rtl/fsfmt_pkg.sv =====
// ----------------------------------------------------------------------------
// fsfmt_pkg: shared types and constants of the format string formatter
// Action codes, controller/datapath command and status bundles, and the
// character constants and hex digit lookup.
// ----------------------------------------------------------------------------
package fsfmt_pkg;

  // Item kinds carried in the input tuser
  localparam logic [1:0] CMD_FMT = 2'd0;
  localparam logic [1:0] CMD_ARG = 2'd1;
  localparam logic [1:0] CMD_STR = 2'd2;

  // Formatter mode
  typedef enum logic [1:0] {
    MODE_PLAIN   = 2'd0,
    MODE_PERCENT = 2'd1,
    MODE_ARG     = 2'd2,
    MODE_STRING  = 2'd3
  } mode_t;

  // Conversion waiting for its argument
  typedef enum logic [2:0] {
    CONV_NONE  = 3'd0,
    CONV_CHAR  = 3'd1,
    CONV_DEC   = 3'd2,
    CONV_HEX32 = 3'd3,
    CONV_HEX64 = 3'd4,
    CONV_STR   = 3'd5
  } conv_t;

  // What an accepted word sets off
  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,   // no character
    ACT_ONE  = 2'd1,   // exactly one character (or an error word)
    ACT_HEX  = 2'd2,   // "0x" and hex digits
    ACT_DEC  = 2'd3    // non-zero signed decimal
  } act_t;

  // ASCII constants
  localparam logic [7:0] CH_ZERO    = 8'h30;  // '0'
  localparam logic [7:0] CH_UPPER_A = 8'h41;  // 'A'
  localparam logic [7:0] CH_X       = 8'h78;  // 'x'
  localparam logic [7:0] CH_MINUS   = 8'h2D;  // '-'
  localparam logic [7:0] CH_QUEST   = 8'h3F;  // '?'
  localparam logic [7:0] CH_PERCENT = 8'h25;  // '%'
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_LC_C    = 8'h63;  // 'c'
  localparam logic [7:0] CH_LC_D    = 8'h64;  // 'd'
  localparam logic [7:0] CH_LC_U    = 8'h75;  // 'u'
  localparam logic [7:0] CH_LC_P    = 8'h70;  // 'p'
  localparam logic [7:0] CH_UC_X    = 8'h58;  // 'X'
  localparam logic [7:0] CH_LC_S    = 8'h73;  // 's'

  localparam logic [3:0] DEC_RADIX  = 4'd10;
  localparam int         DEC_DIGITS = 10;
  localparam int         BIN_BITS   = 32;

  // Controller to datapath commands
  typedef struct packed {
    logic take;       // input word accepted this cycle
    logic hex_emit;   // emit next character of a hex run
    logic conv_step;  // one binary-to-BCD shift
    logic skip_step;  // drop a leading zero digit
    logic dec_emit;   // emit next decimal digit
  } fsfmt_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    act_t act;        // action of the word on the input
    logic out_free;   // output register can take a character
    logic hex_last;   // current hex character ends the run
    logic conv_done;  // current shift is the final one
    logic top_zero;   // leading BCD digit is zero
    logic dig_last;   // current decimal digit is the final one
  } fsfmt_stat_t;

  // Uppercase hex digit
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < DEC_RADIX) r = CH_ZERO + {4'd0, nib};
    else                 r = CH_UPPER_A + {4'd0, nib - DEC_RADIX};
    return r;
  endfunction

endpackage

// ===== hw/rtl/fsfmt_dp.sv =====
// ----------------------------------------------------------------------------
// fsfmt_dp: formatter datapath
// Decodes input words against the mode, holds the hex shifter, the
// binary-to-BCD converter and the output character register.
// ----------------------------------------------------------------------------
module fsfmt_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [1:0]           in_cmd,
  input  logic [7:0]           in_byte,
  input  logic [63:0]          in_arg,
  input  fsfmt_pkg::fsfmt_cmd_t cmd,
  output fsfmt_pkg::fsfmt_stat_t stat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_char,
  output logic                 out_last,
  output logic                 out_err
);
  import fsfmt_pkg::*;

  mode_t        mode, mode_next;
  conv_t        pend, pend_next;
  act_t         act;
  logic [7:0]   one_char;
  logic         one_err;

  logic [63:0]  hex_sr;
  logic [4:0]   hex_idx;
  logic         hex64;

  logic [BIN_BITS-1:0]     bin;
  logic [4*DEC_DIGITS-1:0] bcd;
  logic [4*DEC_DIGITS-1:0] bcd_adj;
  logic [4:0]              bit_cnt;
  logic [3:0]              dig_cnt;
  logic                    neg;
  logic [BIN_BITS-1:0]     mag;

  logic         load;
  logic [7:0]   load_char;
  logic         load_last;
  logic         load_err;

  // add 3 to every BCD digit of five or more
  function automatic logic [4*DEC_DIGITS-1:0] dabble_adj(
    input logic [4*DEC_DIGITS-1:0] v);
    logic [4*DEC_DIGITS-1:0] r;
    logic [3:0] d;
    r = v;
    for (int i = 0; i < DEC_DIGITS; i++) begin
      d = v[4*i +: 4];
      if (d >= 4'd5) r[4*i +: 4] = d + 4'd3;
    end
    return r;
  endfunction

  assign bcd_adj = dabble_adj(bcd);

  assign neg = in_arg[BIN_BITS-1];
  assign mag = neg ? (~in_arg[BIN_BITS-1:0] + BIN_BITS'(1)) : in_arg[BIN_BITS-1:0];

  // decode of the word on the input
  always_comb begin
    mode_next = mode;
    pend_next = pend;
    act       = ACT_NONE;
    one_char  = in_byte;
    one_err   = 1'b0;
    case (mode)
      MODE_PLAIN: begin
        if (in_cmd != CMD_FMT) begin
          act = ACT_ONE; one_char = CH_NUL; one_err = 1'b1;
        end else if (in_byte == CH_PERCENT) begin
          mode_next = MODE_PERCENT;
        end else if (in_byte != CH_NUL) begin
          act = ACT_ONE;
        end
      end
      MODE_PERCENT: begin
        if (in_cmd != CMD_FMT) begin
          act = ACT_ONE; one_char = CH_NUL; one_err = 1'b1;
        end else begin
          mode_next = MODE_ARG;
          case (in_byte)
            CH_LC_C: pend_next = CONV_CHAR;
            CH_LC_D, CH_LC_U: pend_next = CONV_DEC;
            CH_X, CH_LC_P: pend_next = CONV_HEX32;
            CH_UC_X: pend_next = CONV_HEX64;
            CH_LC_S: begin
              pend_next = CONV_STR;
              mode_next = MODE_STRING;
            end
            CH_PERCENT: begin
              act = ACT_ONE; one_char = CH_PERCENT; mode_next = MODE_PLAIN;
            end
            default: begin
              act = ACT_ONE; one_char = CH_QUEST; mode_next = MODE_PLAIN;
            end
          endcase
        end
      end
      MODE_ARG: begin
        if (in_cmd != CMD_ARG) begin
          act = ACT_ONE; one_char = CH_NUL; one_err = 1'b1;
        end else begin
          mode_next = MODE_PLAIN;
          pend_next = CONV_NONE;
          case (pend)
            CONV_CHAR: begin
              act = ACT_ONE; one_char = in_arg[7:0];
            end
            CONV_DEC: begin
              if (in_arg[BIN_BITS-1:0] == '0) begin
                act = ACT_ONE; one_char = CH_ZERO;
              end else begin
                act = ACT_DEC;
              end
            end
            CONV_HEX32, CONV_HEX64: act = ACT_HEX;
            default: act = ACT_NONE;
          endcase
        end
      end
      default: begin
        if (in_cmd != CMD_STR) begin
          act = ACT_ONE; one_char = CH_NUL; one_err = 1'b1;
        end else if (in_byte == CH_NUL) begin
          mode_next = MODE_PLAIN;
          pend_next = CONV_NONE;
        end else begin
          act = ACT_ONE;
        end
      end
    endcase
  end

  // mode and pending conversion
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_PLAIN;
      pend <= CONV_NONE;
    end else if (cmd.take) begin
      mode <= mode_next;
      pend <= pend_next;
    end
  end

  // hex run: "0", "x", then digits from the top nibble
  always_ff @(posedge clk) begin
    if (cmd.take && act == ACT_HEX) begin
      hex64   <= (pend == CONV_HEX64);
      hex_sr  <= (pend == CONV_HEX64) ? in_arg : {in_arg[31:0], 32'd0};
      hex_idx <= '0;
    end else if (cmd.hex_emit) begin
      hex_idx <= hex_idx + 5'd1;
      if (hex_idx >= 5'd2) hex_sr <= {hex_sr[59:0], 4'd0};
    end
  end

  // binary-to-BCD by shift and add-3, then leading zero skip
  always_ff @(posedge clk) begin
    if (cmd.take && act == ACT_DEC) begin
      bin     <= mag;
      bcd     <= '0;
      bit_cnt <= '0;
      dig_cnt <= 4'(DEC_DIGITS);
    end else if (cmd.conv_step) begin
      bcd     <= {bcd_adj[4*DEC_DIGITS-2:0], bin[BIN_BITS-1]};
      bin     <= {bin[BIN_BITS-2:0], 1'b0};
      bit_cnt <= bit_cnt + 5'd1;
    end else if (cmd.skip_step || cmd.dec_emit) begin
      bcd     <= {bcd[4*DEC_DIGITS-5:0], 4'd0};
      dig_cnt <= dig_cnt - 4'd1;
    end
  end

  // character source for the output register
  always_comb begin
    load      = 1'b0;
    load_char = one_char;
    load_last = 1'b1;
    load_err  = 1'b0;
    if (cmd.take && act == ACT_ONE) begin
      load = 1'b1;
      load_err = one_err;
    end else if (cmd.take && act == ACT_DEC && neg) begin
      load = 1'b1;
      load_char = CH_MINUS;
      load_last = 1'b0;
    end else if (cmd.hex_emit) begin
      load = 1'b1;
      load_last = stat.hex_last;
      if (hex_idx == 5'd0)      load_char = CH_ZERO;
      else if (hex_idx == 5'd1) load_char = CH_X;
      else                      load_char = hex_char(hex_sr[63:60]);
    end else if (cmd.dec_emit) begin
      load = 1'b1;
      load_last = stat.dig_last;
      load_char = CH_ZERO + {4'd0, bcd[4*DEC_DIGITS-1 -: 4]};
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char <= load_char;
      out_last <= load_last;
      out_err  <= load_err;
    end
  end

  // status back to the controller
  assign stat.act       = act;
  assign stat.out_free  = !out_valid || out_ready;
  assign stat.hex_last  = hex64 ? (hex_idx == 5'd17) : (hex_idx == 5'd9);
  assign stat.conv_done = (bit_cnt == 5'(BIN_BITS - 1));
  assign stat.top_zero  = (bcd[4*DEC_DIGITS-1 -: 4] == 4'd0);
  assign stat.dig_last  = (dig_cnt == 4'd1);

endmodule

// ===== hw/rtl/fsfmt_ctrl.sv =====
// ----------------------------------------------------------------------------
// fsfmt_ctrl: formatter controller
// Sequences accept, hex emission, decimal conversion, zero skip and digit
// emission, pacing character loads on the output register.
// ----------------------------------------------------------------------------
module fsfmt_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  fsfmt_pkg::fsfmt_stat_t stat,
  output fsfmt_pkg::fsfmt_cmd_t  cmd
);
  import fsfmt_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_HEX   = 5'b00010,
    S_CONV  = 5'b00100,
    S_SKIP  = 5'b01000,
    S_DEMIT = 5'b10000
  } state_t;

  state_t state, state_next;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = stat.out_free;
        if (in_valid && stat.out_free) begin
          cmd.take = 1'b1;
          if (stat.act == ACT_HEX)      state_next = S_HEX;
          else if (stat.act == ACT_DEC) state_next = S_CONV;
        end
      end
      S_HEX: begin
        if (stat.out_free) begin
          cmd.hex_emit = 1'b1;
          if (stat.hex_last) state_next = S_IDLE;
        end
      end
      S_CONV: begin
        cmd.conv_step = 1'b1;
        if (stat.conv_done) state_next = S_SKIP;
      end
      S_SKIP: begin
        if (stat.top_zero) cmd.skip_step = 1'b1;
        else               state_next = S_DEMIT;
      end
      S_DEMIT: begin
        if (stat.out_free) begin
          cmd.dec_emit = 1'b1;
          if (stat.dig_last) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

endmodule

// ===== hw/rtl/format_string_char_formatter.sv =====
// ----------------------------------------------------------------------------
// format_string_char_formatter: streaming printf-style formatter
// Takes format bytes, argument words and string bytes; emits ASCII words.
// ----------------------------------------------------------------------------
// A word that gives one character (plain or string byte, %c, %%, unknown
// directive, zero decimal, protocol error) or none leaves the controller
// idle; the next word is taken only while the output register is empty or
// being read, so it can follow in the next cycle when the output is not stalled.
// A hex argument emits "0x" and 8 or 16 digits at one word per cycle after
// the accepting cycle while the output is not stalled. A non-zero decimal
// argument runs through a shift-and-add-3 binary-to-BCD converter, then
// drops leading zero digits (up to 9) until the first non-zero one, then
// emits a digit a cycle while the output is not stalled. In both cases the
// input is held off until the last character of the run is loaded.
// A protocol error gives one word with tuser high, tdata zero and tlast high.
module format_string_char_formatter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // [7:0] text_byte, [71:8] arg_value
  input  logic [1:0]  s_axis_tuser,   // [1:0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_char
  output logic        m_axis_tlast,   // last_of_run
  output logic [0:0]  m_axis_tuser    // [0] protocol_error
);
  import fsfmt_pkg::*;

  fsfmt_cmd_t  cmd;
  fsfmt_stat_t stat;

  fsfmt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fsfmt_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_cmd    (s_axis_tuser),
    .in_byte   (s_axis_tdata[7:0]),
    .in_arg    (s_axis_tdata[71:8]),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_char  (m_axis_tdata),
    .out_last  (m_axis_tlast),
    .out_err   (m_axis_tuser[0])
  );

endmodule
